@@ design/es2c_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2c_pkg: shared types and constants for the epoch to calendar converter
// Constants of the calendar, divider request/response types, month table.
// ----------------------------------------------------------------------------
package es2c_pkg;

  localparam int unsigned SEC_W  = 32;
  localparam int unsigned DIVS_W = 17;  // widest divisor / remainder
  localparam int unsigned CNT_W  = 6;   // dividend bit count, up to SEC_W

  localparam logic [DIVS_W-1:0] SECS_PER_DAY = 17'd86400;
  localparam logic [DIVS_W-1:0] SECS_PER_MIN = 17'd60;

  localparam logic [11:0] BASE_YEAR   = 12'd1970;
  localparam logic [11:0] MAX_YEAR    = 12'd4095;
  localparam logic [11:0] NOLEAP_YEAR = 12'd2100;
  localparam logic [8:0]  LEAP_DAYS   = 9'd366;
  localparam logic [8:0]  COMMON_DAYS = 9'd365;
  localparam logic [3:0]  LAST_MONTH  = 4'd12;
  localparam logic [3:0]  FEBRUARY    = 4'd2;

  typedef struct packed {
    logic              start;
    logic [DIVS_W-1:0] divisor;
    logic [CNT_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SEC_W-1:0]  quot;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'b00) && (year != NOLEAP_YEAR);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month,
                                           input logic       leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ design/es2c_sdiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2c_sdiv: bit-serial restoring divider
// Dividend is left-aligned in a 32-bit shift register; one quotient bit per
// cycle until nbits quotient bits are formed, then done pulses with quotient and remainder.
// ----------------------------------------------------------------------------
module es2c_sdiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  es2c_pkg::div_req_t          req,
  input  logic [es2c_pkg::SEC_W-1:0]  dividend,
  output es2c_pkg::div_rsp_t          rsp
);
  import es2c_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SEC_W-1:0]  num_r;
  logic [SEC_W-1:0]  quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] div_r;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // remainder stays below the divisor, so trial < 2 * divisor
  assign trial = {rem_r, num_r[SEC_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
        div_r  <= req.divisor;
        num_r  <= dividend;
        quo_r  <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        quo_r <= {quo_r[SEC_W-2:0], ge};
        num_r <= {num_r[SEC_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ design/epoch_seconds_to_calendar_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top: seconds since 1970 to calendar date/time
// Serial divide into day/time fields, then year and month walks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one 32-bit seconds count per
//   request. Output channel out_valid/out_stall returns one request with
//   second, minute, hour, day of month, month and year.
//   Steps: the bit-serial divider divides by 86400, then twice by 60, one
//   quotient bit per cycle; then a year walk counts whole years after 1970
//   (up to 136), a month walk counts whole months (up to 11), and the
//   result loads into the output register.
//   One request is in flight at a time; in_stall is high from acceptance
//   until the result moves into the output register. The output register
//   parts the two sides, so the next request may be accepted while a
//   result still waits on out_stall.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   out_valid. A stalled result holds until out_stall falls.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_number,
  output logic [11:0] out_full_year
);
  import es2c_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DAY, S_SEC, S_MIN, S_YEAR, S_MONTH, S_DONE
  } state_t;

  state_t           state_r;
  logic [15:0]      days_r;
  logic [5:0]       sec_r;
  logic [5:0]       min_r;
  logic [4:0]       hour_r;
  logic [11:0]      year_r;
  logic [3:0]       month_r;
  logic             out_valid_r;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [SEC_W-1:0] div_dividend;

  logic             leap;
  logic [8:0]       ylen;
  logic [4:0]       mlen;
  logic             out_load;

  es2c_sdiv u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .rsp      (div_rsp)
  );

  assign leap     = is_leap(year_r);
  assign ylen     = leap ? LEAP_DAYS : COMMON_DAYS;
  assign mlen     = month_len(month_r, leap && (month_r == FEBRUARY));
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    div_req.start   = 1'b0;
    div_req.divisor = SECS_PER_MIN;
    div_req.nbits   = CNT_W'(SEC_W);
    div_dividend    = in_epoch_seconds;
    unique case (state_r)
      S_IDLE: begin
        div_req.start   = in_valid;
        div_req.divisor = SECS_PER_DAY;
      end
      S_DAY: begin
        // seconds of day, 17 bits, left-aligned
        div_req.start = div_rsp.done;
        div_req.nbits = CNT_W'(17);
        div_dividend  = {div_rsp.rem, 15'd0};
      end
      S_SEC: begin
        // minutes of day, 11 bits, left-aligned
        div_req.start = div_rsp.done;
        div_req.nbits = CNT_W'(11);
        div_dividend  = {div_rsp.quot[10:0], 21'd0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid)
            state_r <= S_DAY;
        end
        S_DAY: begin
          if (div_rsp.done) begin
            days_r  <= div_rsp.quot[15:0];
            state_r <= S_SEC;
          end
        end
        S_SEC: begin
          if (div_rsp.done) begin
            sec_r   <= div_rsp.rem[5:0];
            state_r <= S_MIN;
          end
        end
        S_MIN: begin
          if (div_rsp.done) begin
            min_r   <= div_rsp.rem[5:0];
            hour_r  <= div_rsp.quot[4:0];
            year_r  <= BASE_YEAR;
            state_r <= S_YEAR;
          end
        end
        S_YEAR: begin
          if ((days_r >= {7'd0, ylen}) && (year_r != MAX_YEAR)) begin
            days_r <= days_r - {7'd0, ylen};
            year_r <= year_r + 12'd1;
          end else begin
            month_r <= 4'd1;
            state_r <= S_MONTH;
          end
        end
        S_MONTH: begin
          if ((month_r < LAST_MONTH) && (days_r >= {11'd0, mlen})) begin
            days_r  <= days_r - {11'd0, mlen};
            month_r <= month_r + 4'd1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_second_of_minute <= sec_r;
            out_minute_of_hour   <= min_r;
            out_hour_of_day      <= hour_r;
            out_day_of_month     <= days_r[4:0] + 5'd1;
            out_month_number     <= month_r;
            out_full_year        <= year_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
